// ===== rtl/core/prsq_pkg.sv =====
package prsq_pkg;

    // Operating modes carried by the mode field
    localparam logic [1:0] MODE_ENQUEUE = 2'd0;
    localparam logic [1:0] MODE_DEQUEUE = 2'd1;
    localparam logic [1:0] MODE_CLEAR   = 2'd2;
    localparam logic [1:0] MODE_QUERY   = 2'd3;

    // Configuration register indexes
    localparam logic CFG_PACKETS_PER_FRAME = 1'b0;
    localparam logic CFG_FRAME_NUMBER      = 1'b1;

    // Field widths fixed by the interface
    localparam int COUNT_W   = 10;
    localparam int MISSING_W = 11;
    localparam int HANDLE_W  = 16;
    localparam int FIELD_W   = 16;
    localparam int CFG_W     = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Per-cycle command broadcast to every cell of the row
    typedef struct packed {
        logic enq;   // insert the new entry (store not full)
        logic deq;   // shift every entry one place toward the head
        logic clr;   // drop all entries
    } cell_ctl_t;

endpackage

// ===== rtl/core/packet_reorder_sorted_queue.sv =====
// Channel | Direction | Handshake          | Payload
// input   | in        | in_valid/in_stall  | mode, packet_handle, packet_index, packet_frame
// output  | out       | out_valid/out_stall| popped_*, received_count, missing_count,
//         |           |                    | store_empty, same_frame, dropped
// config  | in        | cfg_we             | cfg_index, cfg_data
//
// One transfer per cycle while in_stall is low: the row of sorted cells inserts or pops in one step,
// every cell comparing its key against the new one and shifting to its neighbor.
// The result is registered and appears in the cycle after the input is accepted.
// Reset clears the cell valid flags and counters at once; no clearing sweep.
// in_stall is high while a result is held by out_stall.
module packet_reorder_sorted_queue
    import prsq_pkg::*;
#(
    parameter int CAPACITY   = 32,
    parameter int INDEX_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // input channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           mode,
    input  logic [HANDLE_W-1:0]  packet_handle,
    input  logic [FIELD_W-1:0]   packet_index,
    input  logic [FIELD_W-1:0]   packet_frame,
    // output channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 popped_valid,
    output logic [HANDLE_W-1:0]  popped_handle,
    output logic [FIELD_W-1:0]   popped_index,
    output logic [COUNT_W-1:0]   received_count,
    output logic signed [MISSING_W-1:0] missing_count,
    output logic                 store_empty,
    output logic                 same_frame,
    output logic                 dropped,
    // configuration port
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic                  in_accept;
    logic                  full;
    cell_ctl_t             ctl;
    logic [INDEX_BITS-1:0] new_key;
    logic [INDEX_BITS+FIELD_W-1:0] key_ext;
    logic [INDEX_BITS+FIELD_W-1:0] pop_ext;

    logic [CAPACITY-1:0]   cell_valid;
    logic [CAPACITY-1:0]   cell_gt;
    logic [INDEX_BITS-1:0] cell_key    [CAPACITY];
    logic [HANDLE_W-1:0]   cell_handle [CAPACITY];

    logic [COUNT_W-1:0]    ppf_reg;
    logic [FIELD_W-1:0]    frame_reg;
    logic [COUNT_W-1:0]    total_reg;
    logic [COUNT_W-1:0]    total_next;

    logic                  out_valid_reg;
    logic                  popped_valid_reg;
    logic [HANDLE_W-1:0]   popped_handle_reg;
    logic [FIELD_W-1:0]    popped_index_reg;
    logic [COUNT_W-1:0]    received_count_reg;
    logic [MISSING_W-1:0]  missing_count_reg;
    logic                  store_empty_reg;
    logic                  same_frame_reg;
    logic                  dropped_reg;
    logic                  pop_hit;
    logic                  empty_after;

    // Handshake: hold input while a result waits
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign full      = cell_valid[CAPACITY-1];

    // Sort key is the low INDEX_BITS bits of the index field
    assign key_ext = {{INDEX_BITS{1'b0}}, packet_index};
    assign new_key = key_ext[INDEX_BITS-1:0];

    // Commands for the cell row
    always_comb
    begin
        ctl.enq = in_accept && (mode == MODE_ENQUEUE) && !full;
        ctl.deq = in_accept && (mode == MODE_DEQUEUE);
        ctl.clr = in_accept && (mode == MODE_CLEAR);
    end

    // Row of sorted cells, head at index 0
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                  l_valid;
        logic                  l_gt;
        logic [INDEX_BITS-1:0] l_key;
        logic [HANDLE_W-1:0]   l_handle;
        logic                  r_valid;
        logic [INDEX_BITS-1:0] r_key;
        logic [HANDLE_W-1:0]   r_handle;

        if (i == 0)
        begin : g_head
            assign l_valid  = 1'b1;
            assign l_gt     = 1'b0;
            assign l_key    = '0;
            assign l_handle = '0;
        end
        else
        begin : g_mid_l
            assign l_valid  = cell_valid[i-1];
            assign l_gt     = cell_gt[i-1];
            assign l_key    = cell_key[i-1];
            assign l_handle = cell_handle[i-1];
        end

        if (i == CAPACITY-1)
        begin : g_tail
            assign r_valid  = 1'b0;
            assign r_key    = '0;
            assign r_handle = '0;
        end
        else
        begin : g_mid_r
            assign r_valid  = cell_valid[i+1];
            assign r_key    = cell_key[i+1];
            assign r_handle = cell_handle[i+1];
        end

        prsq_cell #(
            .INDEX_BITS (INDEX_BITS)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctl          (ctl),
            .new_key      (new_key),
            .new_handle   (packet_handle),
            .left_valid   (l_valid),
            .left_gt      (l_gt),
            .left_key     (l_key),
            .left_handle  (l_handle),
            .right_valid  (r_valid),
            .right_key    (r_key),
            .right_handle (r_handle),
            .valid        (cell_valid[i]),
            .gt           (cell_gt[i]),
            .key          (cell_key[i]),
            .handle       (cell_handle[i])
        );
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppf_reg   <= '0;
            frame_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PACKETS_PER_FRAME: ppf_reg   <= cfg_data[COUNT_W-1:0];
                CFG_FRAME_NUMBER:      frame_reg <= cfg_data;
                default:               ;
            endcase
        end
    end

    // Saturating received count
    always_comb
    begin
        total_next = total_reg;
        if (ctl.clr)
        begin
            total_next = '0;
        end
        else if (ctl.enq && (total_reg != COUNT_MAX))
        begin
            total_next = total_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else
        begin
            total_reg <= total_next;
        end
    end

    // Result fields
    assign pop_hit = ctl.deq && cell_valid[0];
    assign pop_ext = {{FIELD_W{1'b0}}, cell_key[0]};

    always_comb
    begin
        empty_after = !cell_valid[0];
        case (mode)
            MODE_ENQUEUE: empty_after = 1'b0;
            MODE_DEQUEUE: empty_after = !cell_valid[1];
            MODE_CLEAR:   empty_after = 1'b1;
            default:      empty_after = !cell_valid[0];
        endcase
    end

    // Output register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register: payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            popped_valid_reg   <= pop_hit;
            popped_handle_reg  <= pop_hit ? cell_handle[0] : '0;
            popped_index_reg   <= pop_hit ? pop_ext[FIELD_W-1:0] : '0;
            received_count_reg <= total_next;
            missing_count_reg  <= {1'b0, ppf_reg} - {1'b0, total_next};
            store_empty_reg    <= empty_after;
            same_frame_reg     <= (packet_frame == frame_reg);
            dropped_reg        <= (mode == MODE_ENQUEUE) && full;
        end
    end

    assign out_valid      = out_valid_reg;
    assign popped_valid   = popped_valid_reg;
    assign popped_handle  = popped_handle_reg;
    assign popped_index   = popped_index_reg;
    assign received_count = received_count_reg;
    assign missing_count  = missing_count_reg;
    assign store_empty    = store_empty_reg;
    assign same_frame     = same_frame_reg;
    assign dropped        = dropped_reg;

    // Occupied cells form one run from the head
    a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot({1'b0, cell_valid} + {{CAPACITY{1'b0}}, 1'b1}))
        else $error("cell row has a gap");

    // A clear empties the row and reports an empty store
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clr |=> (cell_valid == '0) && store_empty_reg && (total_reg == '0))
        else $error("clear did not empty the store");

    // A drop is reported exactly when an enqueue met a full row
    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (mode == MODE_ENQUEUE)) |=> (dropped_reg == $past(full)))
        else $error("drop flag does not match store fullness");

    // Store is empty exactly when the head cell is empty
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (store_empty_reg == !cell_valid[0]))
        else $error("empty flag disagrees with cell row");

    // The two head entries stay in key order
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid[1] |-> (cell_key[0] <= cell_key[1]))
        else $error("head entries out of order");

endmodule

// ===== rtl/core/prsq_cell.sv =====
module prsq_cell
    import prsq_pkg::*;
#(
    parameter int INDEX_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cell_ctl_t             ctl,
    input  logic [INDEX_BITS-1:0] new_key,
    input  logic [HANDLE_W-1:0]   new_handle,
    // neighbor toward the head
    input  logic                  left_valid,
    input  logic                  left_gt,
    input  logic [INDEX_BITS-1:0] left_key,
    input  logic [HANDLE_W-1:0]   left_handle,
    // neighbor toward the tail
    input  logic                  right_valid,
    input  logic [INDEX_BITS-1:0] right_key,
    input  logic [HANDLE_W-1:0]   right_handle,
    // held entry
    output logic                  valid,
    output logic                  gt,
    output logic [INDEX_BITS-1:0] key,
    output logic [HANDLE_W-1:0]   handle
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [INDEX_BITS-1:0] key_reg;
    logic [INDEX_BITS-1:0] key_next;
    logic [HANDLE_W-1:0]   handle_reg;
    logic [HANDLE_W-1:0]   handle_next;
    logic                  insert_here;

    // New entry goes in front of this one when this key is strictly larger
    assign gt = valid_reg && (key_reg > new_key);

    // First slot that is empty or holds a larger key takes the new entry
    assign insert_here = !left_gt && left_valid && (gt || !valid_reg);

    // Next entry: cleared on clear, shift from the left on insert, from the right on pop
    always_comb
    begin
        valid_next  = valid_reg;
        key_next    = key_reg;
        handle_next = handle_reg;
        if (ctl.clr)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.enq)
        begin
            if (left_gt)
            begin
                valid_next  = left_valid;
                key_next    = left_key;
                handle_next = left_handle;
            end
            else if (insert_here)
            begin
                valid_next  = 1'b1;
                key_next    = new_key;
                handle_next = new_handle;
            end
        end
        else if (ctl.deq)
        begin
            valid_next  = right_valid;
            key_next    = right_key;
            handle_next = right_handle;
        end
    end

    // Occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Entry payload
    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        handle_reg <= handle_next;
    end

    assign valid  = valid_reg;
    assign key    = key_reg;
    assign handle = handle_reg;

endmodule

// ===== tb/sv/packet_reorder_sorted_queue_tb.sv =====
module packet_reorder_sorted_queue_tb;
    import prsq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY   = 32;
    localparam int INDEX_BITS = 16;
    localparam int HOLD_LEN   = 80;

    typedef struct packed {
        logic [1:0]          mode;
        logic [HANDLE_W-1:0] handle;
        logic [FIELD_W-1:0]  index;
        logic [FIELD_W-1:0]  frame;
    } reorder_pkt_t;

    typedef struct packed {
        logic                        popped_valid;
        logic [HANDLE_W-1:0]         popped_handle;
        logic [FIELD_W-1:0]          popped_index;
        logic [COUNT_W-1:0]          received_count;
        logic signed [MISSING_W-1:0] missing_count;
        logic                        store_empty;
        logic                        same_frame;
        logic                        dropped;
    } reorder_res_t;

    // DUT signals; the driven inputs are known from time zero
    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [1:0]                  mode = MODE_QUERY;
    logic [HANDLE_W-1:0]         packet_handle = '0;
    logic [FIELD_W-1:0]          packet_index = '0;
    logic [FIELD_W-1:0]          packet_frame = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic                        popped_valid;
    logic [HANDLE_W-1:0]         popped_handle;
    logic [FIELD_W-1:0]          popped_index;
    logic [COUNT_W-1:0]          received_count;
    logic signed [MISSING_W-1:0] missing_count;
    logic                        store_empty;
    logic                        same_frame;
    logic                        dropped;
    logic                        cfg_we = 1'b0;
    logic                        cfg_index = CFG_PACKETS_PER_FRAME;
    logic [CFG_W-1:0]            cfg_data = '0;

    // stimulus and scoreboard storage
    reorder_pkt_t pending_pkts[$];
    reorder_res_t due_results[$];
    int           mismatches = 0;
    int           send_idle = 0;
    int           recv_idle = 0;
    bit           in_taken = 1'b0;
    bit           hold_req = 1'b0;
    int           hold_cycles = 0;

    // shadow of the sorted store and registers
    logic [FIELD_W-1:0]  key_mem[CAPACITY];
    logic [HANDLE_W-1:0] handle_mem[CAPACITY];
    int                  fill = 0;
    logic [COUNT_W-1:0]  rx_count = '0;
    logic [COUNT_W-1:0]  exp_pkts = '0;
    logic [15:0]         cfg_frame = '0;

    packet_reorder_sorted_queue #(
        .CAPACITY   (CAPACITY),
        .INDEX_BITS (INDEX_BITS)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .packet_handle  (packet_handle),
        .packet_index   (packet_index),
        .packet_frame   (packet_frame),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .popped_valid   (popped_valid),
        .popped_handle  (popped_handle),
        .popped_index   (popped_index),
        .received_count (received_count),
        .missing_count  (missing_count),
        .store_empty    (store_empty),
        .same_frame     (same_frame),
        .dropped        (dropped),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #5 clk = ~clk;

    // Expected result of one packet; updates the shadow store
    function automatic reorder_res_t reorder_step(reorder_pkt_t p);
        reorder_res_t r;
        int           pos;
        int           i;
        r = '0;
        case (p.mode)
            MODE_ENQUEUE:
            begin
                if (fill == CAPACITY)
                begin
                    r.dropped = 1'b1;
                end
                else
                begin
                    pos = 0;
                    while (pos < fill && key_mem[pos] <= p.index)
                        pos++;
                    for (i = fill; i > pos; i--)
                    begin
                        key_mem[i]    = key_mem[i-1];
                        handle_mem[i] = handle_mem[i-1];
                    end
                    key_mem[pos]    = p.index;
                    handle_mem[pos] = p.handle;
                    fill++;
                    if (rx_count != COUNT_MAX)
                        rx_count++;
                end
            end
            MODE_DEQUEUE:
            begin
                if (fill != 0)
                begin
                    r.popped_valid  = 1'b1;
                    r.popped_handle = handle_mem[0];
                    r.popped_index  = key_mem[0];
                    for (i = 1; i < fill; i++)
                    begin
                        key_mem[i-1]    = key_mem[i];
                        handle_mem[i-1] = handle_mem[i];
                    end
                    fill--;
                end
            end
            MODE_CLEAR:
            begin
                fill     = 0;
                rx_count = '0;
            end
            MODE_QUERY:
            begin
            end
        endcase
        r.received_count = rx_count;
        r.missing_count  = {1'b0, exp_pkts} - {1'b0, rx_count};
        r.store_empty    = (fill == 0);
        r.same_frame     = (p.frame == cfg_frame);
        return r;
    endfunction

    // Input driver: next packet offered once the current one transfers
    always @(negedge clk)
    begin : drive_in
        reorder_pkt_t nxt;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (pending_pkts.size() != 0 && $urandom_range(0, 99) >= send_idle)
            begin
                nxt           = pending_pkts.pop_front();
                in_valid      <= 1'b1;
                mode          <= nxt.mode;
                packet_handle <= nxt.handle;
                packet_index  <= nxt.index;
                packet_frame  <= nxt.frame;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output stall: random, or a long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_req && hold_cycles < HOLD_LEN)
        begin
            hold_cycles <= hold_cycles + 1;
            out_stall   <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < recv_idle);
        end
    end

    // Monitor: register writes, result checks, predictions
    always @(posedge clk)
    begin : monitor
        reorder_res_t got;
        reorder_res_t want;
        reorder_pkt_t pkt;
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_PACKETS_PER_FRAME)
                    exp_pkts = cfg_data[COUNT_W-1:0];
                else
                    cfg_frame = cfg_data;
            end
            if (out_valid && !out_stall)
            begin
                got = '{popped_valid, popped_handle, popped_index, received_count,
                        missing_count, store_empty, same_frame, dropped};
                if (due_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer at %0t", $realtime);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch at %0t", $realtime);
                            $display("  expected pv=%0b ph=%h pi=%h rc=%0d mc=%0d se=%0b sf=%0b dr=%0b",
                                     want.popped_valid, want.popped_handle,
                                     want.popped_index, want.received_count,
                                     want.missing_count, want.store_empty,
                                     want.same_frame, want.dropped);
                            $display("  actual   pv=%0b ph=%h pi=%h rc=%0d mc=%0d se=%0b sf=%0b dr=%0b",
                                     got.popped_valid, got.popped_handle,
                                     got.popped_index, got.received_count,
                                     got.missing_count, got.store_empty,
                                     got.same_frame, got.dropped);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                pkt = '{mode, packet_handle, packet_index, packet_frame};
                due_results.push_back(reorder_step(pkt));
            end
        end
    end

    function automatic logic [15:0] rand16();
        logic [31:0] v;
        v = $urandom;
        return v[15:0];
    endfunction

    task automatic add_pkt(input logic [1:0] m, input logic [15:0] h,
                           input logic [15:0] k, input logic [15:0] f);
        reorder_pkt_t p;
        p = '{m, h, k, f};
        pending_pkts.push_back(p);
    endtask

    task automatic write_cfg(input logic idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Idle: nothing queued, nothing offered, no result outstanding
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_pkts.size() != 0 || in_valid || due_results.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    // One frame: clear, enqueue in scrambled order, drain to empty or past it
    task automatic add_frame_burst(input int n, input logic [15:0] fnum);
        int          keys[$];
        int          base;
        int          i;
        int          j;
        int          tmp;
        bit          dup;
        logic [15:0] f;
        base = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535 - n) : 0;
        dup  = ($urandom_range(0, 3) == 0);
        add_pkt(MODE_CLEAR, rand16(), rand16(), fnum);
        for (i = 0; i < n; i++)
            keys.push_back(dup ? base + $urandom_range(0, n / 2) : base + i);
        for (i = n - 1; i > 0; i--)
        begin
            j       = $urandom_range(0, i);
            tmp     = keys[i];
            keys[i] = keys[j];
            keys[j] = tmp;
        end
        for (i = 0; i < n; i++)
        begin
            f = ($urandom_range(0, 7) == 0) ? rand16() : fnum;
            add_pkt(MODE_ENQUEUE, rand16(), keys[i][15:0], f);
            if ($urandom_range(0, 7) == 0)
                add_pkt(MODE_QUERY, rand16(), rand16(), fnum);
        end
        for (i = n + $urandom_range(0, 2); i > 0; i--)
            add_pkt(MODE_DEQUEUE, rand16(), rand16(), fnum);
    endtask

    // Unstructured traffic of any mode
    task automatic add_noise(input int k, input logic [15:0] fnum);
        int          i;
        logic [15:0] key;
        logic [1:0]  m;
        for (i = 0; i < k; i++)
        begin
            m   = 2'($urandom_range(0, 3));
            key = $urandom_range(0, 1) ? 16'($urandom_range(0, 15)) : rand16();
            add_pkt(m, rand16(), key, $urandom_range(0, 1) ? fnum : rand16());
        end
    endtask

    // Long run without clears: interleaved enqueue and dequeue runs
    task automatic add_steady_stream(input int enq_total, input logic [15:0] fnum);
        int sent;
        int i;
        int k;
        sent = 0;
        while (sent < enq_total)
        begin
            k = $urandom_range(1, 6);
            for (i = 0; i < k; i++)
                add_pkt(MODE_ENQUEUE, rand16(), rand16(),
                        ($urandom_range(0, 9) == 0) ? rand16() : fnum);
            sent += k;
            for (i = $urandom_range(1, 6); i > 0; i--)
                add_pkt(MODE_DEQUEUE, rand16(), rand16(), fnum);
            if ($urandom_range(0, 15) == 0)
                add_pkt(MODE_QUERY, rand16(), rand16(), fnum);
        end
    endtask

    // Mixed phase of frame bursts and noise, opening with an overflowing frame
    task automatic add_mixed_phase(input int target, input logic [15:0] fnum);
        add_frame_burst(CAPACITY + 2, fnum);
        while (pending_pkts.size() < target)
        begin
            if ($urandom_range(0, 9) < 7)
                add_frame_burst($urandom_range(1, CAPACITY + 3), fnum);
            else
                add_noise($urandom_range(1, 12), fnum);
        end
    endtask

    // Run limit
    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // Sequencer
    initial
    begin : sequencer
        logic [15:0] fnum;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part
        send_idle = 18;
        recv_idle = 70;
        write_cfg(CFG_PACKETS_PER_FRAME, 16'd3);
        write_cfg(CFG_FRAME_NUMBER, 16'hA5A5);
        add_pkt(MODE_QUERY, 16'h0000, 16'h0000, 16'hA5A5);      // frame match
        add_pkt(MODE_QUERY, 16'hFFFF, 16'hFFFF, 16'h5A5A);      // frame mismatch
        add_pkt(MODE_DEQUEUE, 16'h1234, 16'h4321, 16'hA5A5);    // pop from empty
        add_pkt(MODE_ENQUEUE, 16'hFFFF, 16'hFFFF, 16'hA5A5);    // largest key
        add_pkt(MODE_ENQUEUE, 16'h0000, 16'h0000, 16'hA5A5);    // smallest key
        add_pkt(MODE_ENQUEUE, 16'h1111, 16'h0007, 16'hA5A5);
        add_pkt(MODE_ENQUEUE, 16'h2222, 16'h0007, 16'h0000);    // equal key, arrives later
        add_pkt(MODE_QUERY, 16'h0000, 16'h0000, 16'hFFFF);      // count past expected
        repeat (5) add_pkt(MODE_DEQUEUE, 16'hBEEF, 16'hCAFE, 16'hA5A5);
        add_pkt(MODE_ENQUEUE, 16'h3333, 16'h0003, 16'hA5A5);
        add_pkt(MODE_ENQUEUE, 16'h4444, 16'h8000, 16'hA5A5);
        add_pkt(MODE_CLEAR, 16'hFFFF, 16'hFFFF, 16'hA5A5);      // clear with entries held
        add_pkt(MODE_QUERY, 16'h5555, 16'h5555, 16'hA5A5);
        add_pkt(MODE_DEQUEUE, 16'h0000, 16'h0000, 16'hFFFF);
        add_pkt(MODE_ENQUEUE, 16'h6666, 16'h0001, 16'hFFFF);
        add_pkt(MODE_DEQUEUE, 16'hFFFF, 16'hFFFF, 16'h0000);
        wait_idle();

        // sender mostly busy, receiver mostly stalled; registers at zero
        write_cfg(CFG_PACKETS_PER_FRAME, 16'd0);
        write_cfg(CFG_FRAME_NUMBER, 16'h0000);
        add_mixed_phase(300, 16'h0000);
        wait_idle();

        // roles swapped; registers at their maximum, junk above the count field
        send_idle = 70;
        recv_idle = 18;
        write_cfg(CFG_PACKETS_PER_FRAME, 16'hFC00 | 16'd1023);
        write_cfg(CFG_FRAME_NUMBER, 16'hFFFF);
        add_mixed_phase(300, 16'hFFFF);
        wait_idle();

        // full rate, long hold-off up front, long run without clears
        send_idle = 0;
        recv_idle = 0;
        fnum      = rand16();
        write_cfg(CFG_PACKETS_PER_FRAME, 16'($urandom_range(1, 1022)));
        write_cfg(CFG_FRAME_NUMBER, fnum);
        add_pkt(MODE_CLEAR, 16'h0000, 16'h0000, fnum);
        add_steady_stream(300, fnum);
        hold_req = 1'b1;
        wait_idle();

        repeat (8) @(posedge clk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/prsq_pkg.sv
rtl/core/prsq_cell.sv
rtl/core/packet_reorder_sorted_queue.sv
tb/sv/packet_reorder_sorted_queue_tb.sv
